FILE: rtl/fhal_pkg.sv
// ----------------------------------------------------------------------------
// fhal_pkg
// Shared types and constants of the FNV-hashed answer lookup unit.
// ----------------------------------------------------------------------------
package fhal_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [8:0]  POS_MAX   = 9'd511;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic CFG_KEY_LENGTH = 1'b0;
    localparam logic CFG_KEY_OFFSET = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_NO_TABLE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [15:0] table_caid;
        logic [15:0] table_srvid;
        logic [7:0]  data_byte;
        logic        last;
        logic [63:0] answer_high;
        logic [63:0] answer_low;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out;

    // one finished key or request, handed from front to back
    typedef struct packed {
        logic         opcode;
        logic [31:0]  tkey;
        logic [31:0]  hash;
        logic         complete;
        logic [63:0]  answer_high;
        logic [63:0]  answer_low;
    } t_desc;

    // request buffer write, front to back
    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [7:0] data;
    } t_rq_wr;

endpackage

FILE: rtl/fnv_hashed_answer_lookup_unit.sv
// ----------------------------------------------------------------------------
// fnv_hashed_answer_lookup_unit
// Exact-match answer store with FNV-1a hashed bucket chains.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle, while the input is not stalled, and hashed
// on the fly; a finished key or request waits in a two-deep queue for the
// execution engine. Key bytes go to a single request buffer, so a key-window
// byte of the next transaction stalls while a job is queued or running; bytes
// outside the window still flow until the queue is full. After reset the
// bucket heads and the request buffer are swept with input stalled. Per job
// the engine starts, reduces the hash to a bucket, compares the tables one
// by one and settles the search, which may end the job at once; an insert
// then copies the key byte by byte and links the new entry, and a lookup
// walks the chain, checking each entry's tag and, on a tag match, comparing
// the key byte by byte until a mismatch moves on to the next entry. The
// result is then handed off, waiting while the output stalls. These engine
// steps set the throughput.
module fnv_hashed_answer_lookup_unit #(
    parameter int MAX_TABLES    = 16,
    parameter int BUCKETS       = 1024,
    parameter int MAX_ENTRIES   = 4096,
    parameter int MAX_KEY_BYTES = 200
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fhal_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output fhal_pkg::t_out  o_out_data
);
    import fhal_pkg::*;

    logic [7:0] r_key_length, r_key_offset;
    logic [7:0] eff_len;
    t_rq_wr     rq_wr;
    t_desc      job;
    logic       job_valid, job_pop, clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 8'd16;
            r_key_offset <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data;
                CFG_KEY_OFFSET: r_key_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_key_length == 8'd0) begin
            eff_len = 8'd1;
        end else if (r_key_length > 8'(MAX_KEY_BYTES)) begin
            eff_len = 8'(MAX_KEY_BYTES);
        end else begin
            eff_len = r_key_length;
        end
    end

    fhal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_len       (eff_len),
        .i_offset    (r_key_offset),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data      (i_in_data),
        .o_rq_wr     (rq_wr),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    fhal_back #(
        .MAX_TABLES    (MAX_TABLES),
        .BUCKETS       (BUCKETS),
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (eff_len),
        .i_rq_wr     (rq_wr),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

FILE: rtl/fhal_front.sv
// ----------------------------------------------------------------------------
// fhal_front
// Byte intake: key window selection, FNV-1a hashing, two-deep job queue.
// ----------------------------------------------------------------------------
module fhal_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic [7:0]     i_len,
    input  logic [7:0]     i_offset,
    input  logic           i_valid,
    output logic           o_stall,
    input  fhal_pkg::t_in  i_data,
    output fhal_pkg::t_rq_wr o_rq_wr,
    output logic           o_job_valid,
    output fhal_pkg::t_desc o_job,
    input  logic           i_job_pop
);
    import fhal_pkg::*;

    logic [8:0]  r_pos, n_pos;
    logic [31:0] r_hash;
    t_desc       r_q [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_cnt;

    logic        acc, push, in_win;
    logic [8:0]  start, diff;
    logic [9:0]  win_end;
    logic [31:0] h_mix, h_next;
    t_desc       job;

    // one shared request buffer: window bytes wait while the engine owns it
    assign o_stall = i_hold || (r_cnt == 2'd2) || ((r_cnt != 2'd0) && in_win);
    assign acc     = i_valid && !o_stall;
    assign push    = acc && i_data.last;

    assign start   = (i_data.opcode == OP_LOOKUP) ? {1'b0, i_offset} : 9'd0;
    assign diff    = r_pos - start;
    assign in_win  = (r_pos >= start) && (diff < {1'b0, i_len});
    assign h_mix   = r_hash ^ {24'd0, i_data.data_byte};
    assign h_next  = in_win ? h_mix * FNV_PRIME : r_hash;
    assign n_pos   = (r_pos < POS_MAX) ? r_pos + 9'd1 : r_pos;
    assign win_end = {1'b0, start} + {2'b00, i_len};

    always_comb begin
        job.opcode      = i_data.opcode;
        job.tkey        = {i_data.table_caid, i_data.table_srvid};
        job.hash        = h_next;
        job.complete    = {1'b0, n_pos} >= win_end;
        job.answer_high = i_data.answer_high;
        job.answer_low  = i_data.answer_low;
    end

    always_comb begin
        o_rq_wr.we   = acc && in_win;
        o_rq_wr.idx  = diff[7:0];
        o_rq_wr.data = i_data.data_byte;
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hash <= FNV_BASIS;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (acc) begin
                if (i_data.last) begin
                    r_pos  <= '0;
                    r_hash <= FNV_BASIS;
                end else begin
                    r_pos  <= n_pos;
                    r_hash <= h_next;
                end
            end
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_job_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_job_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job;
        end
    end

endmodule

FILE: rtl/fhal_back.sv
// ----------------------------------------------------------------------------
// fhal_back
// Job execution: table search, bucket select, chain walk, key copy/compare.
// ----------------------------------------------------------------------------
module fhal_back #(
    parameter int MAX_TABLES    = 16,
    parameter int BUCKETS       = 1024,
    parameter int MAX_ENTRIES   = 4096,
    parameter int MAX_KEY_BYTES = 200
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_len,
    input  fhal_pkg::t_rq_wr i_rq_wr,
    input  logic             i_job_valid,
    input  fhal_pkg::t_desc  i_job,
    output logic             o_job_pop,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_stall,
    output fhal_pkg::t_out   o_data
);
    import fhal_pkg::*;

    localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int TCW   = $clog2(MAX_TABLES + 1);
    localparam int BIW   = $clog2(BUCKETS);
    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int LW    = $clog2(MAX_ENTRIES + 1);
    localparam int KD    = MAX_ENTRIES * MAX_KEY_BYTES;
    localparam int KAW   = $clog2(KD);
    localparam int RQD   = MAX_KEY_BYTES;
    localparam int RQW   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CLR_N = (BUCKETS > MAX_KEY_BYTES) ? BUCKETS : MAX_KEY_BYTES;
    localparam int CLRW  = $clog2(CLR_N);

    localparam logic [31:0] BKT32 = 32'(BUCKETS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_MOD   = 15'b000000000000100,
        S_TRD   = 15'b000000000001000,
        S_TCMP  = 15'b000000000010000,
        S_TDONE = 15'b000000000100000,
        S_HEAD  = 15'b000000001000000,
        S_CRD   = 15'b000000010000000,
        S_CWR   = 15'b000000100000000,
        S_INS   = 15'b000001000000000,
        S_WALK  = 15'b000010000000000,
        S_ETAG  = 15'b000100000000000,
        S_KRD   = 15'b001000000000000,
        S_KCMP  = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    t_state          r_state;
    logic [CLRW-1:0] r_clr;
    logic [BIW-1:0]  r_mod;
    logic [1:0]      r_mcnt;
    logic [63:0]     r_prod;
    logic [31:0]     r_rem;
    logic [TCW-1:0]  r_idx, r_tcnt;
    logic            r_found;
    logic [TW-1:0]   r_tbl;
    logic [LW-1:0]   r_ecnt, r_link;
    logic [EW-1:0]   r_e;
    logic [KAW-1:0]  r_kbase;
    logic [7:0]      r_ki;
    t_out            r_res;
    logic            r_ov;
    t_out            r_od;

    // memories
    logic [31:0]        tk_mem [MAX_TABLES];
    logic [LW-1:0]      bh_mem [BUCKETS];
    logic [LW-1:0]      en_next [MAX_ENTRIES];
    logic [TW+31:0]     en_tag [MAX_ENTRIES];
    logic [63:0]        en_ahi [MAX_ENTRIES];
    logic [63:0]        en_alo [MAX_ENTRIES];
    logic [7:0]         key_mem [KD];
    logic [7:0]         rq_mem [RQD];

    logic [31:0]        r_tk_rd;
    logic [LW-1:0]      r_bh_rd, r_nx_rd;
    logic [TW+31:0]     r_tag_rd;
    logic [63:0]        r_ahi_rd, r_alo_rd;
    logic [7:0]         r_key_rd, r_rq_rd;

    logic               tk_we, bh_we, en_we, key_we;
    logic               bh_clr, rq_clr;
    logic [TW-1:0]      tk_ra;
    logic [BIW-1:0]     bh_wa;
    logic [LW-1:0]      bh_wd;
    logic [EW-1:0]      en_ra;
    logic [KAW-1:0]     key_wa, key_ra;
    logic [RQW-1:0]     rq_wa, rq_ra;
    logic               load_out;

    logic [EW-1:0]      e_new, link_e;
    logic               last_k;

    assign e_new  = r_ecnt[EW-1:0];
    assign link_e = EW'(r_link - LW'(1));
    assign last_k = (r_ki + 8'd1) == i_len;

    assign tk_ra  = r_idx[TW-1:0];
    assign en_ra  = link_e;
    assign key_ra = r_kbase + KAW'(r_ki);
    assign key_wa = r_kbase + KAW'(r_ki);
    assign rq_wa  = RQW'(i_rq_wr.idx);
    assign rq_ra  = RQW'(r_ki);

    // the reset sweep clears bucket heads and the request buffer
    assign bh_clr = (r_state == S_CLEAR) && ({1'b0, r_clr} < (CLRW+1)'(BUCKETS));
    assign rq_clr = (r_state == S_CLEAR) && ({1'b0, r_clr} < (CLRW+1)'(MAX_KEY_BYTES));

    assign tk_we  = (r_state == S_TDONE) && (i_job.opcode == OP_INSERT) && i_job.complete
                    && !r_found && (r_tcnt < TCW'(MAX_TABLES)) && (r_ecnt < LW'(MAX_ENTRIES));
    assign bh_we  = bh_clr || (r_state == S_INS);
    assign bh_wa  = (r_state == S_CLEAR) ? BIW'(r_clr) : r_mod;
    assign bh_wd  = (r_state == S_CLEAR) ? '0 : r_ecnt + LW'(1);
    assign en_we  = (r_state == S_INS);
    assign key_we = (r_state == S_CWR);

    assign load_out   = (r_state == S_OUT) && (!r_ov || !i_stall);
    assign o_job_pop  = load_out;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_ov;
    assign o_data     = r_od;

    always_ff @(posedge i_clk) begin
        if (tk_we) begin
            tk_mem[r_tcnt[TW-1:0]] <= i_job.tkey;
        end
        r_tk_rd <= tk_mem[tk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bh_we) begin
            bh_mem[bh_wa] <= bh_wd;
        end
        r_bh_rd <= bh_mem[r_mod];
    end

    always_ff @(posedge i_clk) begin
        if (en_we) begin
            en_next[e_new] <= r_link;
            en_tag[e_new]  <= {r_tbl, i_job.hash};
            en_ahi[e_new]  <= i_job.answer_high;
            en_alo[e_new]  <= i_job.answer_low;
        end
        if (r_state == S_WALK) begin
            r_nx_rd  <= en_next[en_ra];
            r_tag_rd <= en_tag[en_ra];
            r_ahi_rd <= en_ahi[en_ra];
            r_alo_rd <= en_alo[en_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= r_rq_rd;
        end
        r_key_rd <= key_mem[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rq_clr) begin
            rq_mem[RQW'(r_clr)] <= '0;
        end else if (i_rq_wr.we) begin
            rq_mem[rq_wa] <= i_rq_wr.data;
        end
        r_rq_rd <= rq_mem[rq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_od <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_tcnt  <= '0;
            r_ecnt  <= '0;
            r_ov    <= 1'b0;
            r_mod   <= '0;
            r_mcnt  <= '0;
            r_prod  <= '0;
            r_rem   <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_tbl   <= '0;
            r_link  <= '0;
            r_e     <= '0;
            r_kbase <= '0;
            r_ki    <= '0;
            r_res   <= '0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLRW'(1);
                    if (r_clr == CLRW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_mod  <= '0;
                    r_mcnt <= '0;
                    r_idx  <= '0;
                    r_found <= 1'b0;
                    r_ki   <= '0;
                    r_res  <= '0;
                    if (i_job_valid) begin
                        r_state <= S_MOD;
                    end
                end
                // hash mod BUCKETS: reciprocal quotient is low by at most one,
                // so one compare and subtract finishes the remainder
                S_MOD: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd0) begin
                        r_prod <= 64'(i_job.hash) * 64'(RECIP);
                    end else if (r_mcnt == 2'd1) begin
                        r_rem <= i_job.hash - r_prod[63:32] * BKT32;
                    end else begin
                        r_mod   <= (r_rem >= BKT32) ? BIW'(r_rem - BKT32) : r_rem[BIW-1:0];
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    if (r_idx >= r_tcnt) begin
                        r_state <= S_TDONE;
                    end else begin
                        r_state <= S_TCMP;
                    end
                end
                S_TCMP: begin
                    if (r_tk_rd == i_job.tkey) begin
                        r_found <= 1'b1;
                        r_tbl   <= r_idx[TW-1:0];
                        r_state <= S_TDONE;
                    end else begin
                        r_idx   <= r_idx + TCW'(1);
                        r_state <= S_TRD;
                    end
                end
                S_TDONE: begin
                    r_kbase <= KAW'(e_new * MAX_KEY_BYTES);
                    if (i_job.opcode == OP_INSERT) begin
                        if (!i_job.complete) begin
                            r_res.status <= ST_MISS;
                            r_state      <= S_OUT;
                        end else if ((!r_found && r_tcnt >= TCW'(MAX_TABLES))
                                     || r_ecnt >= LW'(MAX_ENTRIES)) begin
                            r_res.status <= ST_FULL;
                            r_state      <= S_OUT;
                        end else begin
                            if (!r_found) begin
                                r_tbl  <= r_tcnt[TW-1:0];
                                r_tcnt <= r_tcnt + TCW'(1);
                            end
                            r_state <= S_HEAD;
                        end
                    end else begin
                        if (!r_found) begin
                            r_res.status <= ST_NO_TABLE;
                            r_state      <= S_OUT;
                        end else if (!i_job.complete) begin
                            r_res.status <= ST_MISS;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_link <= r_bh_rd;
                    if (i_job.opcode == OP_INSERT) begin
                        r_state <= S_CRD;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    r_ki <= r_ki + 8'd1;
                    if (last_k) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_CRD;
                    end
                end
                S_INS: begin
                    r_ecnt       <= r_ecnt + LW'(1);
                    r_res.status <= ST_OK;
                    r_state      <= S_OUT;
                end
                S_WALK: begin
                    r_ki <= '0;
                    if (r_link == '0) begin
                        r_res.status <= ST_MISS;
                        r_state      <= S_OUT;
                    end else begin
                        r_e     <= link_e;
                        r_state <= S_ETAG;
                    end
                end
                S_ETAG: begin
                    if (r_tag_rd == {r_tbl, i_job.hash}) begin
                        r_kbase <= KAW'(r_e * MAX_KEY_BYTES);
                        r_state <= S_KRD;
                    end else begin
                        r_link  <= r_nx_rd;
                        r_state <= S_WALK;
                    end
                end
                S_KRD: begin
                    r_state <= S_KCMP;
                end
                S_KCMP: begin
                    if (r_key_rd != r_rq_rd) begin
                        r_link  <= r_nx_rd;
                        r_state <= S_WALK;
                    end else if (last_k) begin
                        r_res.status      <= ST_OK;
                        r_res.result_high <= r_ahi_rd;
                        r_res.result_low  <= r_alo_rd;
                        r_state           <= S_OUT;
                    end else begin
                        r_ki    <= r_ki + 8'd1;
                        r_state <= S_KRD;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/fhal_checker.sv
// ----------------------------------------------------------------------------
// fhal_checker
// Port-level checks of the lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module fhal_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input fhal_pkg::t_out o_out_data
);
    import fhal_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // answer bits only come with a hit
    a_zero_on_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.result_high == 64'd0 && o_out_data.result_low == 64'd0)
        else $error("nonzero answer without hit");

    // bucket sweep keeps input stalled right after reset
    a_sweep_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input open during bucket sweep");

    // nothing leaves right after reset
    a_quiet_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result right after reset");

endmodule

bind fnv_hashed_answer_lookup_unit fhal_checker u_fhal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
